// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each clock edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sida_pkg.sv
// Shared types and constants for the signed integer to decimal text block.
// No dependencies.
`default_nettype none

package sida_pkg;

    // Decimal digits held: enough for the magnitude 2**63
    localparam int DIGITS = 19;
    localparam int IDX_W  = $clog2(DIGITS);
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(DIGITS - 1);

    localparam logic [5:0] ASCII_ZERO  = 6'd48;
    localparam logic [5:0] ASCII_MINUS = 6'd45;

    // Shift-add-3 correction
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef logic [DIGITS-1:0][3:0] t_bcd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// File: rtl/sida_dabble.sv
// One shift-add-3 step of the binary to BCD conversion.
// Depends on sida_pkg.
`default_nettype none

module sida_dabble (
    input  sida_pkg::t_bcd i_bcd,
    input  logic           i_bit,
    output sida_pkg::t_bcd o_bcd
);
    import sida_pkg::*;

    t_bcd w_adj;

    // Correct every digit of five or more, then shift the new bit in
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            w_adj[d] = (i_bcd[d] >= BCD_ADJ_MIN) ? (i_bcd[d] + BCD_ADJ) : i_bcd[d];
        end
    end

    assign o_bcd = t_bcd'({w_adj[DIGITS-1:0], i_bit});

endmodule

`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii.sv
// Steps per word: accept, VALUE_WIDTH shift-add-3 steps through the shared step
// unit, the sign step (minus sign for negative values), a leading-zero scan, then
// one character per digit; sign and digits wait while the output register is full.
// One word at a time; the next is taken as soon as the last character is in
// the output register. Synchronous active-low reset clears all control state.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side; tdata: value[63:0]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,
    // master side; tdata: char_code[5:0], zero[7:6]; tlast: last_char
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);
    import sida_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    t_state                   r_state, n_state;
    logic [VALUE_WIDTH-1:0]   r_mag, n_mag;
    t_bcd                     r_bcd, n_bcd;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_neg, n_neg;
    logic                     r_ovalid, n_ovalid;
    logic [5:0]               r_ochar, n_ochar;
    logic                     r_olast, n_olast;

    logic [VALUE_WIDTH-1:0]   w_raw;
    t_bcd                     w_bcd_step;
    logic [3:0]               w_digit;
    logic                     w_slot;

    assign w_raw   = i_s_tdata[VALUE_WIDTH-1:0];
    assign w_digit = r_bcd[r_idx];
    assign w_slot  = !r_ovalid || i_m_tready;

    // Shared conversion step
    sida_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bit (r_mag[VALUE_WIDTH-1]),
        .o_bcd (w_bcd_step)
    );

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_neg    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_neg    <= n_neg;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_bcd   <= n_bcd;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    // Sequencer: convert, emit a minus sign if negative, skip leading zeros, emit digits
    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_neg    = r_neg;
        n_ovalid = r_ovalid && !i_m_tready;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_neg   = w_raw[VALUE_WIDTH-1];
                    n_mag   = w_raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~w_raw + 1'b1) : w_raw;
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(VALUE_WIDTH - 1);
                    n_idx   = TOP_IDX;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = w_bcd_step;
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = ST_SIGN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_SIGN: begin
                if (!r_neg) begin
                    n_state = ST_SCAN;
                end else if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_ochar  = ASCII_MINUS;
                    n_olast  = 1'b0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_digit == 4'd0 && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_ochar  = ASCII_ZERO + {2'b00, w_digit};
                    n_olast  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_ochar};
    assign o_m_tlast  = r_olast;

endmodule

`default_nettype wire

// File: rtl/sida_checker.sv
// Port-level checks for signed_int_to_decimal_ascii, with the bind that attaches them.
// Depends on assert_macros.svh and sida_pkg.
`default_nettype none
`include "assert_macros.svh"

module sida_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  i_m_tdata,
    input logic        i_m_tlast
);
    import sida_pkg::*;

    localparam logic [5:0] ASCII_NINE = ASCII_ZERO + 6'd9;

    logic [5:0] w_code;
    logic [8:0] w_out_word;
    logic       w_stall;
    logic       w_minus;
    logic       w_code_ok;

    // Decode the output word
    assign w_code     = i_m_tdata[5:0];
    assign w_out_word = {i_m_tlast, i_m_tdata};
    assign w_stall    = i_m_tvalid && !i_m_tready;
    assign w_minus    = (w_code == ASCII_MINUS);
    assign w_code_ok  = (i_m_tdata[7:6] == 2'b00)
                        && (w_minus || (w_code >= ASCII_ZERO && w_code <= ASCII_NINE));

    // Hold a stalled output word
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        w_stall |=> (i_m_tvalid && $stable(w_out_word)),
        "stalled output word changed")

    // Only a minus sign or a digit, upper bits zero
    `ASSERT_CLK(a_char_range, i_clk, i_rst_n,
        i_m_tvalid |-> w_code_ok,
        "bad character code")

    // A minus sign is never the last character
    `ASSERT_CLK(a_minus_not_last, i_clk, i_rst_n,
        (i_m_tvalid && w_minus) |-> !i_m_tlast,
        "minus sign marked last")

    // Busy right after taking a word
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n,
        (i_s_tvalid && i_s_tready) |=> !i_s_tready,
        "ready right after accept")

    // Reset empties the output register
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_m_tvalid, "output valid after reset")

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire
